@@ rtl/bft_pkg.sv @@
// ----------------------------------------------------------------------------
// bft_pkg
// Types, constants and a helper function shared by the two-hash bloom filter.
// ----------------------------------------------------------------------------
package bft_pkg;

   localparam int KEY_W      = 8;
   localparam int HASH_W     = 32;
   localparam int FB_W       = 9;    // filter_bytes register width
   localparam int HE_W       = 2;    // hash_enable register width
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   // remainder is taken of hash >> 3, low three bits pick the bit in the byte
   localparam int DVD_W      = HASH_W - 3;
   localparam int DIV_STEPS  = DVD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [HASH_W-1:0] DJB2_START = 32'd5381;
   localparam logic [HASH_W-1:0] OAAT_START = 32'd0;

   localparam logic [FB_W-1:0] FB_RESET = 9'd8;
   localparam logic [HE_W-1:0] HE_RESET = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_BYTES = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HASH_ENABLE  = 2'd1;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   localparam int HE_DJB2 = 0;
   localparam int HE_OAAT = 1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic hash_step;   // key byte transaction taken
      logic key_end;     // that byte closes the key
      logic finalize;    // finish jenkins mix, arm all-set flag
      logic div_load;    // start remainder of selected hash
      logic div_sel;     // 0 djb2, 1 jenkins
      logic div_step;    // one remainder bit
      logic mem_read;    // read filter byte at remainder
      logic mem_update;  // check bit, set it on add
      logic clear_step;  // zero one filter byte
      logic rsp_load;    // load result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic            clear_done;
      logic            div_done;
      logic            kind_test;
      logic            rsp_free;
      logic [HE_W-1:0] hash_en;
   } status_type;

   function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      a = h + (h << 3);
      b = a ^ (a >> 11);
      return b + (b << 15);
   endfunction

endpackage

@@ rtl/bft_req_if.sv @@
// ----------------------------------------------------------------------------
// bft_req_if
// Key byte channel: valid/ready handshake with kind, key byte and last flag.
// ----------------------------------------------------------------------------
interface bft_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [bft_pkg::KEY_W-1:0]  key_byte;
   logic                       last;

   modport source (output valid, kind, key_byte, last, input ready);
   modport sink   (input valid, kind, key_byte, last, output ready);
endinterface

@@ rtl/bft_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bft_rsp_if
// Membership result channel: valid/ready handshake with present flag.
// ----------------------------------------------------------------------------
interface bft_rsp_if;
   logic valid;
   logic ready;
   logic present;

   modport source (output valid, present, input ready);
   modport sink   (input valid, present, output ready);
endinterface

@@ rtl/bft_csr_if.sv @@
// ----------------------------------------------------------------------------
// bft_csr_if
// Register write channel: valid/ready handshake with register index and data.
// ----------------------------------------------------------------------------
interface bft_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bft_pkg::CSR_ADDR_W-1:0]  addr;
   logic [bft_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/bft_ctrl.sv @@
// ----------------------------------------------------------------------------
// bft_ctrl
// Controller: sequences the clearing sweep, byte intake, key finalization, the
// remainder pass of each enabled hash, the filter read-modify-write and the result hand-off.
// ----------------------------------------------------------------------------
module bft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  bft_pkg::status_type  stat,
   output bft_pkg::cmd_type     cmd
);
   import bft_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_FINAL = 8'b0000_0100,
      ST_SEL   = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_RD    = 8'b0010_0000,
      ST_CHK   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      which_ff, which_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      which_in = which_ff;
      cmd      = '0;
      cmd.div_sel = which_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.hash_step = accept;
            cmd.key_end   = accept && req_last;
            if (accept && req_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            which_in     = 1'b0;
            state_in     = ST_SEL;
         end
         ST_SEL: begin
            if (!which_ff) begin
               if (stat.hash_en[HE_DJB2]) begin
                  cmd.div_load = 1'b1;
                  state_in     = ST_DIV;
               end else begin
                  which_in = 1'b1;
               end
            end else begin
               if (stat.hash_en[HE_OAAT]) begin
                  cmd.div_load = 1'b1;
                  state_in     = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CHK;
         end
         ST_CHK: begin
            cmd.mem_update = 1'b1;
            if (!which_ff) begin
               which_in = 1'b1;
               state_in = ST_SEL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.kind_test) begin
               state_in = ST_IDLE;
            end else if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         which_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         which_ff <= which_in;
      end
   end

endmodule

@@ rtl/bft_dpath.sv @@
// ----------------------------------------------------------------------------
// bft_dpath
// Datapath: hash accumulators, config registers, bit-serial remainder unit,
// filter byte memory and the result register.
// ----------------------------------------------------------------------------
module bft_dpath #(
   parameter int MAX_FILTER_BYTES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bft_pkg::cmd_type                  cmd,
   output bft_pkg::status_type               stat,
   input  logic                              req_kind,
   input  logic [bft_pkg::KEY_W-1:0]         req_key_byte,
   input  logic                              csr_we,
   input  logic [bft_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bft_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_present
);
   import bft_pkg::*;

   localparam int ADDR_W = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
   localparam int NCap   = (MAX_FILTER_BYTES > 511) ? 511 : MAX_FILTER_BYTES;
   localparam logic [FB_W-1:0]   N_CAP    = FB_W'(NCap);
   localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAX_FILTER_BYTES - 1);

   // config
   logic [FB_W-1:0] fb_ff;
   logic [HE_W-1:0] he_ff;
   logic [FB_W-1:0] fb_eff;

   // hashing
   logic [HASH_W-1:0] djb2_ff, oaat_ff;
   logic [HASH_W-1:0] h1_ff, h2_ff;
   logic [HASH_W-1:0] sx_byte, djb2_nx, oaat_a, oaat_b, oaat_nx;
   logic [HASH_W-1:0] div_src;
   logic              kind_ff;
   logic              all_set_ff;

   // remainder unit
   logic [DVD_W-1:0]     dvd_ff;
   logic [FB_W-1:0]      rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [2:0]           bit_idx_ff;
   logic [FB_W:0]        trial, rem_nx;

   // filter store
   logic [KEY_W-1:0]  mem [MAX_FILTER_BYTES];
   logic [KEY_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] addr;
   logic              hit;

   logic rsp_valid_ff, rsp_present_ff;

   assign fb_eff = (fb_ff == '0) ? FB_W'(1) : ((fb_ff > N_CAP) ? N_CAP : fb_ff);

   always_comb begin
      sx_byte = {{(HASH_W-KEY_W){req_key_byte[KEY_W-1]}}, req_key_byte};
      if (req_key_byte == '0) begin
         djb2_nx = djb2_ff;
         oaat_nx = oaat_ff;
         oaat_a  = oaat_ff;
         oaat_b  = oaat_ff;
      end else begin
         djb2_nx = (djb2_ff << 5) + djb2_ff + sx_byte;
         oaat_a  = oaat_ff + sx_byte;
         oaat_b  = oaat_a + (oaat_a << 10);
         oaat_nx = oaat_b ^ (oaat_b >> 6);
      end
   end

   assign div_src = cmd.div_sel ? h2_ff : h1_ff;

   // restoring remainder step, rem stays below the divisor
   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      rem_nx = (trial >= {1'b0, fb_eff}) ? (trial - {1'b0, fb_eff}) : trial;
   end

   assign addr = ADDR_W'(rem_ff);
   assign hit  = rd_ff[bit_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff <= FB_RESET;
         he_ff <= HE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FILTER_BYTES: fb_ff <= csr_data;
            CSR_HASH_ENABLE:  he_ff <= csr_data[HE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         djb2_ff <= DJB2_START;
         oaat_ff <= OAAT_START;
      end else if (cmd.hash_step) begin
         if (cmd.key_end) begin
            djb2_ff <= DJB2_START;
            oaat_ff <= OAAT_START;
         end else begin
            djb2_ff <= djb2_nx;
            oaat_ff <= oaat_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_end) begin
         h1_ff   <= djb2_nx;
         h2_ff   <= oaat_nx;
         kind_ff <= req_kind;
      end else if (cmd.finalize) begin
         h2_ff <= oaat_final(h2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finalize) begin
         all_set_ff <= 1'b1;
      end else if (cmd.mem_update && !hit) begin
         all_set_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_load) begin
         cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_ff     <= div_src[HASH_W-1:3];
         bit_idx_ff <= div_src[2:0];
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_nx[FB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mem_update && (kind_ff == KIND_ADD)) begin
         mem[addr] <= rd_ff | (KEY_W'(1) << bit_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_present_ff <= all_set_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

   assign stat.clear_done = (clr_ff == LAST_ADR);
   assign stat.div_done   = (cnt_ff == '0);
   assign stat.kind_test  = (kind_ff == KIND_TEST);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stat.hash_en    = he_ff;

endmodule

@@ rtl/bloom_filter_two_hash_top.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_two_hash_top
// Bloom filter over byte-string keys with djb2 and one-at-a-time hashes.
//
//   channel   dir   handshake          payload
//   req_port  in    valid / ready      kind, key_byte, last
//   rsp_port  out   valid / ready      present (test keys only)
//   csr_port  in    valid / ready      addr, data (ready always high)
//
// A key byte that is not last is taken while ready stays high. A last byte then
// runs finalization and, for each hash, a selection and, if it is enabled, a
// remainder pass, one memory read and one read-modify-write, then the result
// hand-off for a test key; the remainder unit produces one bit per cycle over 29
// bits. After reset the filter store is swept to zero byte by byte, with
// req_port.ready low. A stalled result holds in its output register; the next
// key streams in meanwhile and only its end waits for the slot.
// ----------------------------------------------------------------------------
module bloom_filter_two_hash_top #(
   parameter int MAX_FILTER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   bft_req_if.sink     req_port,
   bft_rsp_if.source   rsp_port,
   bft_csr_if.sink     csr_port
);
   import bft_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_present;

   assign csr_port.ready = 1'b1;
   assign req_port.ready = req_ready;
   assign rsp_port.valid   = rsp_valid;
   assign rsp_port.present = rsp_present;

   bft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_last  (req_port.last),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bft_dpath #(
      .MAX_FILTER_BYTES (MAX_FILTER_BYTES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_port.kind),
      .req_key_byte (req_port.key_byte),
      .csr_we       (csr_port.valid),
      .csr_addr     (csr_port.addr),
      .csr_data     (csr_port.data),
      .rsp_ready    (rsp_port.ready),
      .rsp_valid    (rsp_valid),
      .rsp_present  (rsp_present)
   );

   // key end blocks intake until the filter access is done
   a_key_end_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready && req_port.last) |=> !req_port.ready)
      else $error("input ready right after a key end");

   // only test keys produce a result transaction
   a_rsp_only_test: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (stat.kind_test && stat.rsp_free))
      else $error("result loaded for an add key or into a busy slot");

   // memory read follows the final remainder step
   a_read_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_read |-> $past(cmd.div_step && stat.div_done))
      else $error("filter read without a finished remainder");

   // no intake while the store is being cleared
   a_clear_no_intake: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_port.ready)
      else $error("input ready during clearing sweep");

endmodule

@@ bench/tb_bloom_filter_two_hash_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_two_hash_top
// Self-checking bench for the two-hash bloom filter. Key bytes are streamed
// in as add or test keys under a range of filter sizes and hash enables. A
// shadow filter with its own djb2 and one-at-a-time hashing predicts every
// membership answer, and each result is checked in order as it leaves.
// ----------------------------------------------------------------------------
module tb_bloom_filter_two_hash_top;
   import bft_pkg::*;

   localparam int FILTER_DEPTH = 256;
   localparam int MAX_KEY_LEN  = 12;
   localparam int POOL_SIZE    = 16;
   localparam int ITEM_TARGET  = 1450;
   localparam int TAIL_CYCLES  = 120;    // longest key end plus the result slot
   localparam int SWEEP_STEPS  = 10;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  key_byte;
      logic              last;
   } key_item_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_NORMAL, SINK_HEAVY} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bft_req_if req_bus ();
   bft_rsp_if rsp_bus ();
   bft_csr_if csr_bus ();

   bloom_filter_two_hash_top #(
      .MAX_FILTER_BYTES(FILTER_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // shadow filter state
   logic [7:0]         shadow_bits [FILTER_DEPTH];
   logic [HASH_W-1:0]  djb2_run;
   logic [HASH_W-1:0]  oaat_run;
   logic [FB_W-1:0]    shadow_fbytes;
   logic [HE_W-1:0]    shadow_hen;
   logic               present_expect_q [$];

   // stimulus state
   logic [KEY_W-1:0]   key_buf [MAX_KEY_LEN];
   int                 key_len;
   logic [KEY_W-1:0]   pool_bytes [POOL_SIZE][MAX_KEY_LEN];
   int                 pool_len [POOL_SIZE];
   int                 pool_wr = 0;
   int                 pool_fill = 0;
   bit                 src_idle_on = 1'b1;
   sink_mode_type      sink_mode = SINK_NORMAL;
   int                 rsp_hold = 0;

   logic [FB_W-1:0] sweep_fb [SWEEP_STEPS] = '{9'd256, 9'd511, 9'd100, 9'd8, 9'd0,
                                               9'd1, 9'd2, 9'd37, 9'd64, 9'd3};
   logic [HE_W-1:0] sweep_he [SWEEP_STEPS] = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd3,
                                               2'd2, 2'd1, 2'd0, 2'd3, 2'd3};

   int items_sent      = 0;
   int adds_seen       = 0;
   int tests_seen      = 0;
   int results_checked = 0;
   int reg_writes      = 0;
   int fail_count      = 0;

   // ------------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------------
   function automatic logic [HASH_W-1:0] filter_bit_total();
      logic [HASH_W-1:0] n;
      n = HASH_W'(shadow_fbytes);
      if (n < 1) n = 1;
      if (n > FILTER_DEPTH) n = FILTER_DEPTH;
      return n * 8;
   endfunction

   // returns the bit before any set
   function automatic logic probe_bit(input logic [HASH_W-1:0] h, input logic do_set);
      logic [HASH_W-1:0] pos;
      int unsigned       idx;
      logic              was;
      pos = h % filter_bit_total();
      idx = pos >> 3;
      was = shadow_bits[idx][pos[2:0]];
      if (do_set) shadow_bits[idx][pos[2:0]] = 1'b1;
      return was;
   endfunction

   task automatic hash_and_mark(input key_item_type it);
      logic [HASH_W-1:0] c;
      logic [HASH_W-1:0] h_djb;
      logic [HASH_W-1:0] h_oaat;
      logic              is_test;
      logic              all_set;
      // a zero byte leaves both accumulators alone
      if (it.key_byte != '0) begin
         c = {{(HASH_W-KEY_W){it.key_byte[KEY_W-1]}}, it.key_byte};
         djb2_run = (djb2_run << 5) + djb2_run + c;
         oaat_run = oaat_run + c;
         oaat_run = oaat_run + (oaat_run << 10);
         oaat_run = oaat_run ^ (oaat_run >> 6);
      end
      if (it.last) begin
         h_djb  = djb2_run;
         h_oaat = oaat_run + (oaat_run << 3);
         h_oaat = h_oaat ^ (h_oaat >> 11);
         h_oaat = h_oaat + (h_oaat << 15);
         djb2_run = DJB2_START;
         oaat_run = OAAT_START;
         is_test = (it.kind == KIND_TEST);
         all_set = 1'b1;
         if (shadow_hen[HE_DJB2]) begin
            if (!probe_bit(h_djb, !is_test)) all_set = 1'b0;
         end
         if (shadow_hen[HE_OAAT]) begin
            if (!probe_bit(h_oaat, !is_test)) all_set = 1'b0;
         end
         if (is_test) begin
            present_expect_q.push_back(all_set);
            tests_seen++;
         end else begin
            adds_seen++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // monitors: accepted transactions feed the shadow model and the checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      logic want;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (present_expect_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual present=%0b",
                        $time, rsp_bus.present);
            end else begin
               want = present_expect_q.pop_front();
               results_checked++;
               if (rsp_bus.present !== want) begin
                  fail_count++;
                  $display("%0t: present mismatch, expected %0b, actual %0b",
                           $time, want, rsp_bus.present);
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            hash_and_mark('{kind: req_bus.kind, key_byte: req_bus.key_byte,
                            last: req_bus.last});
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            if (csr_bus.addr == CSR_FILTER_BYTES)
               shadow_fbytes = csr_bus.data[FB_W-1:0];
            else if (csr_bus.addr == CSR_HASH_ENABLE)
               shadow_hen = csr_bus.data[HE_W-1:0];
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : rsp_sink
      int roll;
      if (rsp_hold > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready = 1'b1;
         roll = $urandom_range(0, 99);
         if (sink_mode == SINK_NORMAL && roll < 20)
            rsp_hold = (roll < 17) ? $urandom_range(1, 3) : $urandom_range(15, 80);
         else if (sink_mode == SINK_HEAVY && roll < 50)
            rsp_hold = (roll < 30) ? $urandom_range(1, 4) : $urandom_range(30, 150);
      end
   end

   // ------------------------------------------------------------------------
   // drivers; every task starts and ends on a falling edge
   // ------------------------------------------------------------------------
   function automatic int sender_gap();
      int roll;
      if (!src_idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(input key_item_type it);
      int gap;
      req_bus.kind     = it.kind;
      req_bus.key_byte = it.key_byte;
      req_bus.last     = it.last;
      req_bus.valid    = 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
      gap = sender_gap();
      repeat (gap) @(negedge clock);
   endtask

   task automatic send_key(input logic kind, input bit mixed);
      key_item_type it;
      for (int i = 0; i < key_len; i++) begin
         it.kind     = (mixed && i < key_len - 1) ? 1'($urandom_range(0, 1)) : kind;
         it.key_byte = key_buf[i];
         it.last     = (i == key_len - 1);
         send_byte(it);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.addr  = addr;
      csr_bus.data  = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      reg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // wait out every pending result, then let a trailing add finish
   task automatic settle();
      while (present_expect_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [FB_W-1:0] fb, input logic [HE_W-1:0] he);
      logic [CSR_DATA_W-1:0] he_word;
      settle();
      he_word = CSR_DATA_W'($urandom);
      he_word[HE_W-1:0] = he;
      if ($urandom_range(0, 1)) begin
         csr_write(CSR_FILTER_BYTES, CSR_DATA_W'(fb));
         csr_write(CSR_HASH_ENABLE, he_word);
      end else begin
         csr_write(CSR_HASH_ENABLE, he_word);
         csr_write(CSR_FILTER_BYTES, CSR_DATA_W'(fb));
      end
   endtask

   task automatic load_key(input int len, input logic [KEY_W-1:0] b0,
                           input logic [KEY_W-1:0] b1, input logic [KEY_W-1:0] b2);
      key_len    = len;
      key_buf[0] = b0;
      key_buf[1] = b1;
      key_buf[2] = b2;
   endtask

   task automatic make_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)      key_len = $urandom_range(1, 4);
      else if (roll < 95) key_len = $urandom_range(5, 8);
      else                key_len = $urandom_range(9, MAX_KEY_LEN);
      for (int i = 0; i < key_len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 10)      key_buf[i] = 8'h00;
         else if (roll < 14) key_buf[i] = 8'h80;
         else if (roll < 18) key_buf[i] = 8'hff;
         else if (roll < 20) key_buf[i] = 8'h7f;
         else                key_buf[i] = KEY_W'($urandom);
      end
   endtask

   task automatic stash_key();
      pool_len[pool_wr] = key_len;
      for (int i = 0; i < key_len; i++) pool_bytes[pool_wr][i] = key_buf[i];
      pool_wr = (pool_wr + 1) % POOL_SIZE;
      if (pool_fill < POOL_SIZE) pool_fill++;
   endtask

   task automatic recall_key();
      int slot;
      slot = $urandom_range(0, pool_fill - 1);
      key_len = pool_len[slot];
      for (int i = 0; i < key_len; i++) key_buf[i] = pool_bytes[slot][i];
   endtask

   // mostly add-then-query traffic, with fresh probes and mixed-kind noise
   task automatic random_key_op(input int test_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= test_pct) begin
         make_key();
         send_key(KIND_ADD, 1'b0);
         stash_key();
      end else if (roll < test_pct / 2 && pool_fill > 0) begin
         recall_key();
         send_key(KIND_TEST, 1'b0);
      end else if (roll < test_pct - 8) begin
         make_key();
         send_key(KIND_TEST, 1'b0);
      end else begin
         make_key();
         send_key(1'($urandom_range(0, 1)), 1'b1);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_keys();
      // lone zero byte ends an empty key on an empty filter
      load_key(1, 8'h00, 8'h00, 8'h00);
      send_key(KIND_TEST, 1'b0);
      load_key(1, 8'h61, 8'h00, 8'h00);
      send_key(KIND_ADD, 1'b0);
      send_key(KIND_TEST, 1'b0);
      // sign extension of high bytes
      load_key(2, 8'h80, 8'hff, 8'h00);
      send_key(KIND_ADD, 1'b0);
      send_key(KIND_TEST, 1'b0);
      // zero byte in the middle of a key
      load_key(3, 8'h7f, 8'h00, 8'h01);
      send_key(KIND_TEST, 1'b0);
      // test bytes closed by an add byte act as an add
      load_key(2, 8'h55, 8'haa, 8'h00);
      send_byte('{kind: KIND_TEST, key_byte: 8'h55, last: 1'b0});
      send_byte('{kind: KIND_ADD, key_byte: 8'haa, last: 1'b1});
      send_key(KIND_TEST, 1'b0);
   endtask

   task automatic test_register_extremes();
      // no hash enabled: add is a no-op and every test reports present
      apply_setting(9'd8, 2'd0);
      load_key(1, 8'h33, 8'h00, 8'h00);
      send_key(KIND_TEST, 1'b0);
      load_key(1, 8'h44, 8'h00, 8'h00);
      send_key(KIND_ADD, 1'b0);
      // size zero behaves as one byte
      apply_setting(9'd0, 2'd1);
      load_key(1, 8'hfe, 8'h00, 8'h00);
      send_key(KIND_ADD, 1'b0);
      send_key(KIND_TEST, 1'b0);
      // size above the store clamps to the store
      apply_setting(9'h1ff, 2'd2);
      load_key(2, 8'h01, 8'h02, 8'h00);
      send_key(KIND_TEST, 1'b0);
      send_key(KIND_ADD, 1'b0);
      // writes to unused indexes change nothing
      settle();
      csr_write(CSR_SPARE_2, 9'h1ff);
      csr_write(CSR_SPARE_3, 9'h000);
      send_key(KIND_TEST, 1'b0);
   endtask

   task automatic test_random_sweep(input int reserve);
      int phase_end;
      for (int s = 0; s < SWEEP_STEPS; s++) begin
         apply_setting(sweep_fb[s], sweep_he[s]);
         phase_end = items_sent + (ITEM_TARGET - reserve - items_sent) / (SWEEP_STEPS - s);
         while (items_sent < phase_end) random_key_op(55);
      end
   endtask

   task automatic test_back_to_back(input int count);
      int stop_at;
      apply_setting(9'd128, 2'd3);
      src_idle_on = 1'b0;
      sink_mode   = SINK_OPEN;
      stop_at = items_sent + count;
      while (items_sent < stop_at) random_key_op(50);
      src_idle_on = 1'b1;
      sink_mode   = SINK_NORMAL;
   endtask

   task automatic test_result_backpressure(input int count);
      int stop_at;
      apply_setting(9'd16, 2'd3);
      sink_mode = SINK_HEAVY;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         random_key_op(80);
         // now and then hold the sender until all answers are back
         if ($urandom_range(0, 99) < 5) settle();
      end
      sink_mode = SINK_NORMAL;
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_ADD;
      req_bus.key_byte = '0;
      req_bus.last     = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.addr     = CSR_FILTER_BYTES;
      csr_bus.data     = '0;
      rsp_bus.ready    = 1'b0;
      djb2_run      = DJB2_START;
      oaat_run      = OAAT_START;
      shadow_fbytes = FB_RESET;
      shadow_hen    = HE_RESET;
      for (int i = 0; i < FILTER_DEPTH; i++) shadow_bits[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_keys();
      test_register_extremes();
      test_random_sweep(300);
      test_back_to_back(150);
      test_result_backpressure(150);
      settle();

      $display("covered %0d add and %0d test keys over %0d key bytes, %0d register writes",
               adds_seen, tests_seen, items_sent, reg_writes);
      $display("%0d membership answers checked, filter sizes 1 to %0d bytes, all hash enables",
               results_checked, FILTER_DEPTH);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ bloom_filter_two_hash_top.f @@
rtl/bft_pkg.sv
rtl/bft_req_if.sv
rtl/bft_rsp_if.sv
rtl/bft_csr_if.sv
rtl/bft_ctrl.sv
rtl/bft_dpath.sv
rtl/bloom_filter_two_hash_top.sv
bench/tb_bloom_filter_two_hash_top.sv
